/* sv/fqddm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and codes for the frame queue drop/drain manager.
// No dependencies; used by the top level and its port checker.
package fqddm_pkg;

   // queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int RING_SIZE   = QUEUE_DEPTH + 1;
   localparam int IDX_W       = $clog2(RING_SIZE);
   localparam int FILL_W      = $clog2(RING_SIZE + 1);

   // field widths fixed by the interface
   localparam int ACTION_W  = 2;
   localparam int BUF_W     = 8;
   localparam int COUNT_W   = 32;
   localparam int PEAK_W    = 3;
   localparam int TARGET_W  = 3;
   localparam int TIMEOUT_W = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;

   // shared comparator width, wide enough for the tick counter
   localparam int CMP_W = TIMEOUT_W;

   // drain limit must hold target + 1 and the queue depth
   localparam int LIM_W = (FILL_W > TARGET_W + 1) ? FILL_W : TARGET_W + 1;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_ARRIVE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

   // result kinds
   localparam logic KIND_RELEASE = 1'b0;
   localparam logic KIND_ANSWER  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_DEPTH   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNAL_TIMEOUT = 1'd1;

   // register reset values
   localparam logic [TARGET_W-1:0]  TARGET_RESET  = 3'd1;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;
   localparam logic [TIMEOUT_W-1:0] TICKS_MAX     = 16'hFFFF;

endpackage

/* sv/frame_queue_drop_drain_manager.sv */
`timescale 1ns / 1ps
// Frame queue drop/drain manager: ring of frame ids, held frame and counters
// stepped by a sequencer around one shared comparator; depends on fqddm_pkg.
// Ticks stay in idle; an arrival drains one frame on overflow; a request runs check,
// drain, peak, take, answer or, if refused, only check; result steps wait on rsp_stall.
// Throughput: req_stall is high while the sequencer is busy; reset empties the queue.

module frame_queue_drop_drain_manager (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fqddm_pkg::ACTION_W-1:0]      req_action,
   input  logic [fqddm_pkg::BUF_W-1:0]         req_buffer_id,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic [fqddm_pkg::BUF_W-1:0]         rsp_out_buffer,
   output logic                                rsp_show_valid,
   output logic [fqddm_pkg::COUNT_W-1:0]       rsp_dropped_count,
   output logic [fqddm_pkg::COUNT_W-1:0]       rsp_taken_count,
   output logic [fqddm_pkg::COUNT_W-1:0]       rsp_reused_count,
   output logic [fqddm_pkg::PEAK_W-1:0]        rsp_queue_peak,
   output logic                                rsp_last,
   // configuration
   input  logic                                csr_we,
   input  logic [fqddm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fqddm_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int IDX_W  = fqddm_pkg::IDX_W;
   localparam int FILL_W = fqddm_pkg::FILL_W;
   localparam int LIM_W  = fqddm_pkg::LIM_W;
   localparam int CMP_W  = fqddm_pkg::CMP_W;
   localparam int BUF_W  = fqddm_pkg::BUF_W;
   localparam int CNT_W  = fqddm_pkg::COUNT_W;
   localparam int PK_W   = (FILL_W > fqddm_pkg::PEAK_W) ? FILL_W : fqddm_pkg::PEAK_W;
   localparam int SUM_W  = IDX_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DRAIN,
      ST_PEAK,
      ST_TAKE,
      ST_ANSWER
   } state_type;

   // sequencer and queue state
   state_type                          state_ff, state_in;
   logic                               mode_req_ff, mode_req_in;
   logic [LIM_W-1:0]                   limit_ff, limit_in;
   logic [BUF_W-1:0]                   ring_ff [fqddm_pkg::RING_SIZE];
   logic                               ring_we;
   logic [IDX_W-1:0]                   ring_waddr;
   logic [IDX_W-1:0]                   head_ff, head_in;
   logic [FILL_W-1:0]                  fill_ff, fill_in;
   logic [BUF_W-1:0]                   held_ff, held_in;
   logic                               held_valid_ff, held_valid_in;
   logic [fqddm_pkg::TIMEOUT_W-1:0]    ticks_ff, ticks_in;
   logic                               seen_ff, seen_in;
   logic [CNT_W-1:0]                   drop_ff, drop_in;
   logic [CNT_W-1:0]                   take_ff, take_in;
   logic [CNT_W-1:0]                   reuse_ff, reuse_in;
   logic [FILL_W-1:0]                  peak_ff, peak_in;

   // configuration registers
   logic [fqddm_pkg::TARGET_W-1:0]     target_ff;
   logic [fqddm_pkg::TIMEOUT_W-1:0]    timeout_ff;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_kind_ff, rsp_kind_in;
   logic [BUF_W-1:0]                   rsp_buf_ff, rsp_buf_in;
   logic                               rsp_show_ff, rsp_show_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]                   rsp_drop_ff, rsp_take_ff, rsp_reuse_ff;
   logic [FILL_W-1:0]                  rsp_peak_ff;
   logic [PK_W-1:0]                    rsp_peak_wide;

   // helpers
   logic                               accept;
   logic                               out_free;
   logic                               emit;
   logic [CMP_W-1:0]                   cmp_a, cmp_b;
   logic                               cmp_gt;
   logic [IDX_W-1:0]                   head_step;
   logic [SUM_W-1:0]                   tail_sum;
   logic [IDX_W-1:0]                   tail_idx;
   logic [BUF_W-1:0]                   head_data;
   logic [LIM_W-1:0]                   target_lim;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // ring pointers
   assign head_step = (head_ff == IDX_W'(fqddm_pkg::RING_SIZE - 1)) ? '0 : head_ff + 1'b1;
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(fill_ff);
   assign tail_idx  = (tail_sum >= SUM_W'(fqddm_pkg::RING_SIZE))
                    ? IDX_W'(tail_sum - SUM_W'(fqddm_pkg::RING_SIZE))
                    : IDX_W'(tail_sum);
   assign head_data = ring_ff[head_ff];
   assign target_lim = LIM_W'(target_ff) + LIM_W'(1);

   // shared comparator: operands chosen by the sequencer step
   always_comb begin
      cmp_a = '0;
      cmp_b = '0;
      case (state_ff)
         ST_CHECK: begin
            cmp_a = timeout_ff;
            cmp_b = ticks_ff;
         end
         ST_DRAIN: begin
            cmp_a = CMP_W'(fill_ff);
            cmp_b = CMP_W'(limit_ff);
         end
         ST_PEAK: begin
            cmp_a = CMP_W'(fill_ff);
            cmp_b = CMP_W'(peak_ff);
         end
         ST_TAKE: begin
            cmp_a = CMP_W'(fill_ff);
         end
         default: begin
            cmp_a = '0;
            cmp_b = '0;
         end
      endcase
   end

   assign cmp_gt = (cmp_a > cmp_b);

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      mode_req_in   = mode_req_ff;
      limit_in      = limit_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      ticks_in      = ticks_ff;
      seen_in       = seen_ff;
      drop_in       = drop_ff;
      take_in       = take_ff;
      reuse_in      = reuse_ff;
      peak_in       = peak_ff;
      ring_we       = 1'b0;
      ring_waddr    = tail_idx;
      emit          = 1'b0;
      rsp_kind_in   = fqddm_pkg::KIND_RELEASE;
      rsp_buf_in    = '0;
      rsp_show_in   = 1'b0;
      rsp_last_in   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  fqddm_pkg::ACT_ARRIVE: begin
                     ring_we     = 1'b1;
                     fill_in     = fill_ff + 1'b1;
                     seen_in     = 1'b1;
                     ticks_in    = '0;
                     mode_req_in = 1'b0;
                     limit_in    = LIM_W'(fqddm_pkg::QUEUE_DEPTH);
                     state_in    = ST_DRAIN;
                  end
                  fqddm_pkg::ACT_REQUEST: begin
                     state_in = ST_CHECK;
                  end
                  fqddm_pkg::ACT_TICK: begin
                     if (seen_ff && ticks_ff != fqddm_pkg::TICKS_MAX) begin
                        ticks_in = ticks_ff + 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // signal check: ticks below timeout
         ST_CHECK: begin
            if (out_free) begin
               if (seen_ff && cmp_gt) begin
                  mode_req_in = 1'b1;
                  limit_in    = target_lim;
                  state_in    = ST_DRAIN;
               end else begin
                  emit        = 1'b1;
                  rsp_kind_in = fqddm_pkg::KIND_ANSWER;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end

         // release oldest frames while above the limit
         ST_DRAIN: begin
            if (out_free) begin
               if (cmp_gt) begin
                  head_in     = head_step;
                  fill_in     = fill_ff - 1'b1;
                  drop_in     = drop_ff + 1'b1;
                  emit        = 1'b1;
                  rsp_buf_in  = head_data;
                  rsp_last_in = !mode_req_ff;
                  // an arrival overflows by one frame at most
                  if (!mode_req_ff) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = mode_req_ff ? ST_PEAK : ST_IDLE;
               end
            end
         end

         ST_PEAK: begin
            if (cmp_gt) begin
               peak_in = fill_ff;
            end
            state_in = ST_TAKE;
         end

         // head, if any, becomes the shown frame, the old one goes back to the pool
         ST_TAKE: begin
            if (out_free) begin
               if (cmp_gt) begin
                  head_in       = head_step;
                  fill_in       = fill_ff - 1'b1;
                  take_in       = take_ff + 1'b1;
                  held_in       = head_data;
                  held_valid_in = 1'b1;
                  if (held_valid_ff) begin
                     emit       = 1'b1;
                     rsp_buf_in = held_ff;
                  end
               end else begin
                  reuse_in = reuse_ff + 1'b1;
               end
               state_in = ST_ANSWER;
            end
         end

         ST_ANSWER: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_kind_in = fqddm_pkg::KIND_ANSWER;
               rsp_buf_in  = held_valid_ff ? held_ff : '0;
               rsp_show_in = held_valid_ff;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   // state, configuration and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_req_ff   <= 1'b0;
         head_ff       <= '0;
         fill_ff       <= '0;
         held_valid_ff <= 1'b0;
         ticks_ff      <= '0;
         seen_ff       <= 1'b0;
         drop_ff       <= '0;
         take_ff       <= '0;
         reuse_ff      <= '0;
         peak_ff       <= '0;
         target_ff     <= fqddm_pkg::TARGET_RESET;
         timeout_ff    <= fqddm_pkg::TIMEOUT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_req_ff   <= mode_req_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         held_valid_ff <= held_valid_in;
         ticks_ff      <= ticks_in;
         seen_ff       <= seen_in;
         drop_ff       <= drop_in;
         take_ff       <= take_in;
         reuse_ff      <= reuse_in;
         peak_ff       <= peak_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               fqddm_pkg::CSR_TARGET_DEPTH:
                  target_ff <= csr_wdata[fqddm_pkg::TARGET_W-1:0];
               fqddm_pkg::CSR_SIGNAL_TIMEOUT:
                  timeout_ff <= csr_wdata[fqddm_pkg::TIMEOUT_W-1:0];
               default: begin
                  target_ff <= target_ff;
               end
            endcase
         end
      end

      // payload: no reset
      limit_ff <= limit_in;
      held_ff  <= held_in;
      if (ring_we) begin
         ring_ff[ring_waddr] <= req_buffer_id;
      end
      if (emit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_buf_ff   <= rsp_buf_in;
         rsp_show_ff  <= rsp_show_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_drop_ff  <= drop_in;
         rsp_take_ff  <= take_in;
         rsp_reuse_ff <= reuse_in;
         rsp_peak_ff  <= peak_in;
      end
   end

   // outputs
   assign rsp_peak_wide     = PK_W'(rsp_peak_ff);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_out_buffer    = rsp_buf_ff;
   assign rsp_show_valid    = rsp_show_ff;
   assign rsp_dropped_count = rsp_drop_ff;
   assign rsp_taken_count   = rsp_take_ff;
   assign rsp_reused_count  = rsp_reuse_ff;
   assign rsp_queue_peak    = rsp_peak_wide[fqddm_pkg::PEAK_W-1:0];
   assign rsp_last          = rsp_last_ff;

endmodule

/* sv/fqddm_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the frame queue drop/drain manager, bound to the top.
// Depends on fqddm_pkg.

module fqddm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [fqddm_pkg::ACTION_W-1:0]    req_action,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_kind,
   input logic [fqddm_pkg::BUF_W-1:0]       rsp_out_buffer,
   input logic                              rsp_show_valid,
   input logic                              rsp_last
);

   // a result waiting on stall stays presented
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a display request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == fqddm_pkg::ACT_REQUEST |=> req_stall)
      else $error("request not held busy");

   // releases never carry a frame to show
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == fqddm_pkg::KIND_RELEASE |-> !rsp_show_valid)
      else $error("release flagged as show");

   // an answer without a frame shows buffer zero and ends the request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == fqddm_pkg::KIND_ANSWER && !rsp_show_valid
      |-> rsp_out_buffer == '0 && rsp_last)
      else $error("empty answer malformed");

   // nothing is presented straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind frame_queue_drop_drain_manager fqddm_checker u_fqddm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_action     (req_action),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_out_buffer (rsp_out_buffer),
   .rsp_show_valid (rsp_show_valid),
   .rsp_last       (rsp_last)
);
